### design/buddy_page_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Buddy page allocator - assertion macros
// Shared property macros for the allocator checks, clocked on clk, held off
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, codes and elaboration-time tables shared by the buddy allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  // Defaults for the top-level parameters
  localparam int PAGES_DEF     = 1024;
  localparam int TOP_ORDER_DEF = 10;
  localparam int MAX_ORD       = 16;

  // Fixed field widths
  localparam int ACT_W    = 2;
  localparam int FRAME_W  = 10;
  localparam int ORDER_W  = 4;
  localparam int STATUS_W = 2;
  localparam int PCNT_W   = 11;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [PCNT_W-1:0] PCNT_RST = 11'd1024;

  // Bitmap word geometry
  localparam int WORD_W = 32;
  localparam int WSH    = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_INIT    = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_FREE    = 2'd2,
    ACT_RESERVE = 2'd3
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_MEM   = 2'd1,
    ST_BAD_ARG  = 2'd2,
    ST_NOT_FREE = 2'd3
  } status_t;

  // Bitmap unit operations
  typedef enum logic [1:0] {
    MOP_GET  = 2'd0,
    MOP_PUT  = 2'd1,
    MOP_WORD = 2'd2,
    MOP_CLR  = 2'd3
  } mop_t;

  typedef enum logic [1:0] {
    U_IDLE = 2'd0,
    U_RMW  = 2'd1,
    U_CLR  = 2'd2
  } ust_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_CARVE,
    S_ALLOC_SCAN,
    S_ALLOC_TAKE,
    S_ALLOC_SPLIT,
    S_FREE_SET,
    S_MERGE_GET,
    S_MERGE_CLR_A,
    S_MERGE_CLR_B,
    S_RES_GET,
    S_RES_TAKE,
    S_RES_SPLIT,
    S_FINISH
  } seq_st_t;

  typedef struct packed {
    logic vld;
    mop_t op;
    logic val;
  } bpa_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
  } bpa_rsp_t;

  typedef logic [MAX_ORD:0][31:0] tbl_t;

  // Blocks per order
  function automatic tbl_t blocks_tbl(int pages);
    tbl_t t;
    for (int k = 0; k <= MAX_ORD; k++) begin
      t[k] = 32'(pages >> k);
    end
    return t;
  endfunction

  // Bitmap words per order
  function automatic tbl_t words_tbl(int pages);
    tbl_t t;
    for (int k = 0; k <= MAX_ORD; k++) begin
      t[k] = 32'(((pages >> k) + WORD_W - 1) >> WSH);
    end
    return t;
  endfunction

  // First word of each order's region
  function automatic tbl_t base_tbl(int pages);
    tbl_t t;
    int   acc;
    acc = 0;
    for (int k = 0; k <= MAX_ORD; k++) begin
      t[k] = 32'(acc);
      acc  = acc + (((pages >> k) + WORD_W - 1) >> WSH);
    end
    return t;
  endfunction

  // Position of the lowest set bit
  function automatic logic [WSH-1:0] lsb32(logic [WORD_W-1:0] w);
    logic [WSH-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) r = WSH'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/bpa_bitmap.sv
// ----------------------------------------------------------------------------
// bpa_bitmap
// Free bitmap store: one 32-bit word memory holding every order's map, with
// a read-modify-write bit unit, a word read and a full clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_bitmap
  import bpa_pkg::*;
#(
  parameter int PAGES     = PAGES_DEF,
  parameter int TOP_ORDER = TOP_ORDER_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bpa_cmd_t                     cmd,
  input  wire logic [$clog2(TOP_ORDER+1)-1:0] k_in,
  input  wire logic [$clog2(PAGES)-1:0]     idx_in,
  output bpa_rsp_t                          rsp,
  output logic [WORD_W-1:0]                 word_out
);

  localparam tbl_t BLK_T  = blocks_tbl(PAGES);
  localparam tbl_t WRD_T  = words_tbl(PAGES);
  localparam tbl_t BASE_T = base_tbl(PAGES);
  localparam int   NWORDS = int'(BASE_T[TOP_ORDER]) + int'(WRD_T[TOP_ORDER]);
  localparam int   AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  logic [WORD_W-1:0] map_mem [NWORDS];

  ust_t              st_r, st_nxt;
  logic [AW-1:0]     addr_r, clr_r;
  logic [WSH-1:0]    bit_r;
  logic              inr_r, val_r;
  mop_t              op_r;
  logic [WORD_W-1:0] rdata_r;

  logic [AW-1:0]     addr_c;
  logic              inr_c;
  logic [4:0]        kx;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;

  // Word address and range check for the incoming command
  always_comb begin
    kx = 5'(k_in);
    if (cmd.op == MOP_WORD) begin
      addr_c = AW'(BASE_T[kx] + 32'(idx_in));
    end else begin
      addr_c = AW'(BASE_T[kx] + (32'(idx_in) >> WSH));
    end
    inr_c = (32'(idx_in) < BLK_T[kx]);
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      U_IDLE: begin
        if (cmd.vld) st_nxt = (cmd.op == MOP_CLR) ? U_CLR : U_RMW;
      end
      U_RMW: st_nxt = U_IDLE;
      U_CLR: begin
        if (clr_r == AW'(NWORDS - 1)) st_nxt = U_IDLE;
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    we       = 1'b0;
    waddr    = addr_r;
    wdata    = rdata_r;
    rsp.done = 1'b0;
    rsp.hit  = inr_r & rdata_r[bit_r];
    word_out = rdata_r;
    case (st_r)
      U_RMW: begin
        rsp.done     = 1'b1;
        we           = (op_r == MOP_PUT) && inr_r;
        wdata[bit_r] = val_r;
      end
      U_CLR: begin
        we       = 1'b1;
        waddr    = clr_r;
        wdata    = '0;
        rsp.done = (clr_r == AW'(NWORDS - 1));
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= U_IDLE;
      clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == U_IDLE) clr_r <= '0;
      else if (st_r == U_CLR) clr_r <= clr_r + AW'(1);
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (st_r == U_IDLE && cmd.vld) begin
      addr_r <= addr_c;
      bit_r  <= idx_in[WSH-1:0] & {WSH{cmd.op != MOP_WORD}};
      inr_r  <= inr_c;
      op_r   <= cmd.op;
      val_r  <= cmd.val;
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) map_mem[waddr] <= wdata;
    rdata_r <= map_mem[addr_c];
  end

endmodule

`default_nettype wire

### design/bpa_seq.sv
// ----------------------------------------------------------------------------
// bpa_seq
// Action sequencer: drives the bitmap unit through init carving, allocate
// scan and split, free and merge, and single-frame reserve.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_seq
  import bpa_pkg::*;
#(
  parameter int PAGES     = PAGES_DEF,
  parameter int TOP_ORDER = TOP_ORDER_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [ACT_W-1:0]               act_in,
  input  wire logic [FRAME_W-1:0]             frame_in,
  input  wire logic [ORDER_W-1:0]             order_in,
  input  wire logic [PCNT_W-1:0]              page_count,
  input  wire logic                           out_free,
  output logic                                ready,
  output logic                                fin,
  output logic [STATUS_W-1:0]                 fin_status,
  output logic [FRAME_W-1:0]                  fin_frame,
  output bpa_cmd_t                            cmd,
  output logic [$clog2(TOP_ORDER+1)-1:0]      k_out,
  output logic [$clog2(PAGES)-1:0]            idx_out,
  input  wire bpa_rsp_t                       rsp,
  input  wire logic [WORD_W-1:0]              word_in
);

  localparam int   ORDW = $clog2(TOP_ORDER + 1);
  localparam int   IDXW = $clog2(PAGES);
  localparam int   PW   = $clog2(PAGES + 1);
  localparam tbl_t WRD_T = words_tbl(PAGES);
  localparam int   NW0  = int'(WRD_T[0]);
  localparam int   WW   = (NW0 > 1) ? $clog2(NW0) : 1;

  seq_st_t           st_r, st_nxt;
  logic              wait_r, carve_r;
  act_t              act_r;
  logic [FRAME_W-1:0] frm_r;
  logic [ORDER_W-1:0] ord_r;
  logic [ORDW-1:0]   k_r;
  logic [IDXW-1:0]   idx_r, base_r;
  logic [WW-1:0]     w_r;
  logic [PW-1:0]     rem_r, pos_r;
  status_t           status_r;
  logic [FRAME_W-1:0] granted_r;

  logic [31:0]       size_c;
  logic              rem_ge, w_ok, top_k, k_gt_ord, bad_free, misal;
  logic [IDXW-1:0]   res_idx;
  logic [ORDW-1:0]   k_dn;
  logic              done;

  assign done     = rsp.done;
  assign size_c   = 32'(1) << k_r;
  assign rem_ge   = 32'(rem_r) >= size_c;
  assign w_ok     = 32'(w_r) < WRD_T[5'(k_r)];
  assign top_k    = 32'(k_r) == 32'(TOP_ORDER);
  assign k_gt_ord = 32'(k_r) > 32'(ord_r);
  assign res_idx  = IDXW'(32'(frm_r) >> k_r);
  assign k_dn     = k_r - ORDW'(1);
  assign misal    = (32'(frm_r) & ((32'(1) << ord_r) - 32'(1))) != 32'(0);
  assign bad_free = (32'(ord_r) > 32'(TOP_ORDER)) || misal ||
                    (32'(frm_r) + (32'(1) << ord_r) > 32'(PAGES));

  assign ready      = (st_r == S_IDLE);
  assign fin        = (st_r == S_FINISH) && out_free;
  assign fin_status = status_r;
  assign fin_frame  = granted_r;

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLEAR: if (done) st_nxt = carve_r ? S_CARVE : S_IDLE;
      S_IDLE: if (start) st_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (act_r)
          ACT_INIT:  st_nxt = S_CLEAR;
          ACT_ALLOC: st_nxt = (32'(ord_r) > 32'(TOP_ORDER)) ? S_FINISH : S_ALLOC_SCAN;
          ACT_FREE:  st_nxt = bad_free ? S_FINISH : S_FREE_SET;
          default:   st_nxt = (32'(frm_r) >= 32'(PAGES)) ? S_FINISH : S_RES_GET;
        endcase
      end
      S_CARVE: begin
        if (!rem_ge && k_r == '0) st_nxt = S_FINISH;
      end
      S_ALLOC_SCAN: begin
        if (!w_ok) begin
          if (top_k) st_nxt = S_FINISH;
        end else if (done) begin
          if (word_in != '0) st_nxt = S_ALLOC_TAKE;
          else if (32'(w_r) + 32'(1) >= WRD_T[5'(k_r)] && top_k) st_nxt = S_FINISH;
        end
      end
      S_ALLOC_TAKE:  if (done) st_nxt = S_ALLOC_SPLIT;
      S_ALLOC_SPLIT: if (!k_gt_ord) st_nxt = S_FINISH;
      S_FREE_SET:    if (done) st_nxt = S_MERGE_GET;
      S_MERGE_GET: begin
        if (top_k) st_nxt = S_FINISH;
        else if (done) st_nxt = rsp.hit ? S_MERGE_CLR_A : S_FINISH;
      end
      S_MERGE_CLR_A: if (done) st_nxt = S_MERGE_CLR_B;
      S_MERGE_CLR_B: if (done) st_nxt = S_FREE_SET;
      S_RES_GET: begin
        if (done) begin
          if (rsp.hit) st_nxt = S_RES_TAKE;
          else if (k_r == '0) st_nxt = S_FINISH;
        end
      end
      S_RES_TAKE:  if (done) st_nxt = S_RES_SPLIT;
      S_RES_SPLIT: if (k_r == '0) st_nxt = S_FINISH;
      S_FINISH:    if (out_free) st_nxt = S_IDLE;
      default:     st_nxt = S_IDLE;
    endcase
  end

  // Bitmap commands
  always_comb begin
    cmd.vld = 1'b0;
    cmd.op  = MOP_GET;
    cmd.val = 1'b0;
    k_out   = k_r;
    idx_out = idx_r;
    case (st_r)
      S_CLEAR: begin
        cmd.vld = !wait_r;
        cmd.op  = MOP_CLR;
      end
      S_CARVE: begin
        cmd.vld = !wait_r && rem_ge;
        cmd.op  = MOP_PUT;
        cmd.val = 1'b1;
        idx_out = IDXW'(32'(pos_r) >> k_r);
      end
      S_ALLOC_SCAN: begin
        cmd.vld = !wait_r && w_ok;
        cmd.op  = MOP_WORD;
        idx_out = IDXW'(w_r);
      end
      S_ALLOC_TAKE: begin
        cmd.vld = !wait_r;
        cmd.op  = MOP_PUT;
      end
      S_ALLOC_SPLIT: begin
        cmd.vld = !wait_r && k_gt_ord;
        cmd.op  = MOP_PUT;
        cmd.val = 1'b1;
        k_out   = k_dn;
        idx_out = IDXW'((32'(base_r) >> k_dn) + 32'(1));
      end
      S_FREE_SET: begin
        cmd.vld = !wait_r;
        cmd.op  = MOP_PUT;
        cmd.val = 1'b1;
      end
      S_MERGE_GET: begin
        cmd.vld = !wait_r && !top_k;
        idx_out = idx_r ^ IDXW'(1);
      end
      S_MERGE_CLR_A: begin
        cmd.vld = !wait_r;
        cmd.op  = MOP_PUT;
      end
      S_MERGE_CLR_B: begin
        cmd.vld = !wait_r;
        cmd.op  = MOP_PUT;
        idx_out = idx_r ^ IDXW'(1);
      end
      S_RES_GET: begin
        cmd.vld = !wait_r;
        idx_out = res_idx;
      end
      S_RES_TAKE: begin
        cmd.vld = !wait_r;
        cmd.op  = MOP_PUT;
        idx_out = res_idx;
      end
      S_RES_SPLIT: begin
        cmd.vld = !wait_r && (k_r != '0);
        cmd.op  = MOP_PUT;
        cmd.val = 1'b1;
        k_out   = k_dn;
        idx_out = IDXW'(32'(frm_r) >> k_dn) ^ IDXW'(1);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      wait_r  <= 1'b0;
      carve_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cmd.vld) wait_r <= 1'b1;
      else if (done) wait_r <= 1'b0;
      if (st_r == S_DISPATCH && act_r == ACT_INIT) carve_r <= 1'b1;
      else if (st_r == S_CARVE && !rem_ge && k_r == '0) carve_r <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (start) begin
          act_r <= act_t'(act_in);
          frm_r <= frame_in;
          ord_r <= order_in;
        end
      end
      S_DISPATCH: begin
        status_r  <= ST_OK;
        granted_r <= '0;
        case (act_r)
          ACT_INIT: begin
            rem_r <= (32'(page_count) > 32'(PAGES)) ? PW'(PAGES) : PW'(page_count);
            pos_r <= '0;
            k_r   <= ORDW'(TOP_ORDER);
          end
          ACT_ALLOC: begin
            if (32'(ord_r) > 32'(TOP_ORDER)) status_r <= ST_BAD_ARG;
            k_r <= ORDW'(ord_r);
            w_r <= '0;
          end
          ACT_FREE: begin
            if (bad_free) status_r <= ST_BAD_ARG;
            k_r   <= ORDW'(ord_r);
            idx_r <= IDXW'(32'(frm_r) >> ord_r);
          end
          default: begin
            if (32'(frm_r) >= 32'(PAGES)) status_r <= ST_BAD_ARG;
            k_r <= ORDW'(TOP_ORDER);
          end
        endcase
      end
      S_CARVE: begin
        if (rem_ge) begin
          if (done) begin
            rem_r <= PW'(32'(rem_r) - size_c);
            pos_r <= PW'(32'(pos_r) + size_c);
          end
        end else if (k_r != '0) begin
          k_r <= k_dn;
        end
      end
      S_ALLOC_SCAN: begin
        if (!w_ok) begin
          if (top_k) status_r <= ST_NO_MEM;
          else begin
            k_r <= k_r + ORDW'(1);
            w_r <= '0;
          end
        end else if (done) begin
          if (word_in != '0) begin
            idx_r <= IDXW'({w_r, lsb32(word_in)});
          end else if (32'(w_r) + 32'(1) >= WRD_T[5'(k_r)]) begin
            if (top_k) status_r <= ST_NO_MEM;
            else begin
              k_r <= k_r + ORDW'(1);
              w_r <= '0;
            end
          end else begin
            w_r <= w_r + WW'(1);
          end
        end
      end
      S_ALLOC_TAKE: if (done) base_r <= IDXW'(32'(idx_r) << k_r);
      S_ALLOC_SPLIT: begin
        if (!k_gt_ord) granted_r <= FRAME_W'(32'(base_r));
        else if (done) k_r <= k_dn;
      end
      S_MERGE_CLR_B: begin
        if (done) begin
          k_r   <= k_r + ORDW'(1);
          idx_r <= idx_r >> 1;
        end
      end
      S_RES_GET: begin
        if (done && !rsp.hit) begin
          if (k_r == '0) status_r <= ST_NOT_FREE;
          else k_r <= k_dn;
        end
      end
      S_RES_SPLIT: begin
        if (k_r == '0) granted_r <= frm_r;
        else if (done) k_r <= k_dn;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### design/buddy_page_allocator_core.sv
// Buddy page allocator over PAGES frames, one free bit per block per order.
// Input channel (in_*): one request per transaction: init, allocate, free or
// reserve a single frame. Result channel (out_*): exactly one status/frame
// transaction per request, in request order. Config channel (cfg_*): writes
// page_count, always ready; write it only while no request is in flight.
// One request is worked at a time; in_tready is low from acceptance until the
// sequencer is back to idle. Each bitmap access goes through the single map
// memory port. Allocate: scans bitmap words (up to ceil(PAGES/32) words at
// order 0, fewer higher up), then one access per split. Free: sets the
// block's bit, then per merge level probes the buddy and clears both bits.
// Reserve: one probe per order, then one access per split. Init: a full map
// sweep (one word per cycle, 68 words at PAGES=1024), then one write per
// carved block and a step down per order. After reset the map is swept
// clear (same length as the init sweep) before in_tready rises. A result
// waits in the output register while out_tready is low; the next request may
// be accepted meanwhile, but it cannot finish until that register is free.
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// Top level: stream ports, config register, result register, sequencer and
// bitmap store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "buddy_page_allocator_core_defines.svh"

module buddy_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int PAGES     = PAGES_DEF,
  parameter int TOP_ORDER = TOP_ORDER_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: action [1:0], frame_number [11:2], block_order [15:12]
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: status [1:0], granted_frame [11:2], zero [15:12]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // cfg_data: page_count
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [PCNT_W-1:0]      cfg_data
);

  localparam int ORDW = $clog2(TOP_ORDER + 1);
  localparam int IDXW = $clog2(PAGES);

  logic [PCNT_W-1:0]   page_count_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [FRAME_W-1:0]  out_frame_r;

  logic                start, out_free, seq_ready, fin;
  logic [STATUS_W-1:0] fin_status;
  logic [FRAME_W-1:0]  fin_frame;
  bpa_cmd_t            cmd;
  bpa_rsp_t            rsp;
  logic [ORDW-1:0]     k_sel;
  logic [IDXW-1:0]     idx_sel;
  logic [WORD_W-1:0]   word;

  assign in_tready  = seq_ready;
  assign start      = in_tvalid && seq_ready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - STATUS_W - FRAME_W){1'b0}}, out_frame_r, out_status_r};

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= PCNT_RST;
    end else if (cfg_valid) begin
      page_count_r <= cfg_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_status_r <= fin_status;
      out_frame_r  <= fin_frame;
    end
  end

  bpa_seq #(
    .PAGES     (PAGES),
    .TOP_ORDER (TOP_ORDER)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .act_in     (in_tdata[1:0]),
    .frame_in   (in_tdata[11:2]),
    .order_in   (in_tdata[15:12]),
    .page_count (page_count_r),
    .out_free   (out_free),
    .ready      (seq_ready),
    .fin        (fin),
    .fin_status (fin_status),
    .fin_frame  (fin_frame),
    .cmd        (cmd),
    .k_out      (k_sel),
    .idx_out    (idx_sel),
    .rsp        (rsp),
    .word_in    (word)
  );

  bpa_bitmap #(
    .PAGES     (PAGES),
    .TOP_ORDER (TOP_ORDER)
  ) u_bitmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .k_in     (k_sel),
    .idx_in   (idx_sel),
    .rsp      (rsp),
    .word_out (word)
  );

  // Checks
  `BPA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after accept")
  `BPA_ASSERT_NOW(a_fin_slot_free, fin, !out_valid_r || out_tready, "result overwrites pending result")
  `BPA_ASSERT_NOW(a_fail_zero_frame, out_tvalid && out_tdata[1:0] != ST_OK, out_tdata[11:2] == '0, "failed result carries a frame")

endmodule

`default_nettype wire
